// ----- design/rtcdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RTC date-time codec package
// Beat types, field masks and the small calendar and BCD helper functions
// shared by the date-time codec.
// ----------------------------------------------------------------------------
package rtcdt_pkg;

  localparam logic CmdDecode = 1'b0;
  localparam logic CmdEncode = 1'b1;

  localparam logic [7:0] SecMask   = 8'h7f;
  localparam logic [7:0] MinMask   = 8'h7f;
  localparam logic [7:0] HourMask  = 8'h3f;
  localparam logic [7:0] DayMask   = 8'h3f;
  localparam logic [7:0] WdayMask  = 8'h07;
  localparam logic [7:0] MonMask   = 8'h1f;
  localparam int unsigned OscStopBit = 7;

  localparam logic [15:0] YearBase = 16'd2000;
  localparam logic [15:0] YearLast = 16'd2099;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  second_in;
    logic [7:0]  minute_in;
    logic [7:0]  hour_in;
    logic [7:0]  day_in;
    logic [7:0]  weekday_in;
    logic [7:0]  month_in;
    logic [15:0] year_in;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic        integrity;
    logic [7:0]  second_out;
    logic [7:0]  minute_out;
    logic [7:0]  hour_out;
    logic [7:0]  day_out;
    logic [7:0]  weekday_out;
    logic [7:0]  month_out;
    logic [11:0] year_out;
  } out_beat_t;

  // Tens nibble times ten plus units nibble; non-BCD nibbles pass unchecked.
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
  endfunction

  // Binary value below one hundred to two BCD digits.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {7'd0, v} * 14'd103;
    tens = prod[13:10];
    ones = v - 7'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [4:0] month_len(input logic [7:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: n = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    n = 5'd30;
      8'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // The year must already be known to lie in range.
  function automatic logic date_ok(input logic [7:0] s, input logic [7:0] mi,
                                   input logic [7:0] h, input logic [7:0] d,
                                   input logic [7:0] wd, input logic [7:0] mo,
                                   input logic year_ok, input logic leap);
    logic ok;
    ok = year_ok && (mo >= 8'd1) && (mo <= 8'd12) && (d >= 8'd1) &&
         (d <= {3'd0, month_len(mo, leap)}) && (wd <= 8'd6) &&
         (h <= 8'd23) && (mi <= 8'd59) && (s <= 8'd59);
    return ok;
  endfunction

  // Month term of Zeller's congruence, with January and February counted
  // as months thirteen and fourteen of the previous year.
  function automatic logic [7:0] zeller_month(input logic [7:0] m);
    logic [7:0] t;
    unique case (m)
      8'd1:    t = 8'd36;
      8'd2:    t = 8'd39;
      8'd3:    t = 8'd10;
      8'd4:    t = 8'd13;
      8'd5:    t = 8'd15;
      8'd6:    t = 8'd18;
      8'd7:    t = 8'd20;
      8'd8:    t = 8'd23;
      8'd9:    t = 8'd26;
      8'd10:   t = 8'd28;
      8'd11:   t = 8'd31;
      8'd12:   t = 8'd33;
      default: t = 8'd0;
    endcase
    return t;
  endfunction

  // Remainder by seven, folding on eight being one more than seven.
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [5:0] a;
    logic [3:0] b;
    a = {1'b0, x[7:3]} + {3'd0, x[2:0]};
    b = {1'b0, a[5:3]} + {1'b0, a[2:0]};
    if (b >= 4'd7) begin
      b = b - 4'd7;
    end
    return b[2:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/rtc_datetime_bcd_codec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RTC date-time BCD codec
// Decodes raw real-time-clock register bytes to a checked decimal date-time,
// or checks a decimal date-time and encodes it to BCD register bytes.
// ----------------------------------------------------------------------------
// Every beat takes one pass through an input register, the conversion logic
// and a result register, so a beat can be accepted on every clock. Its result
// is computed from the input register and presented from the result register.
// Only a stall on the output slows the input. A new beat can still enter an
// empty input register while an earlier result is stalled at the output. The
// block holds no state between beats; the weekday on encode is recomputed for
// years 2000 through 2099 with Sunday as zero.
module rtc_datetime_bcd_codec
  import rtcdt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  logic      in_vld_q;
  in_beat_t  in_q;
  logic      out_vld_q;
  out_beat_t out_q;
  out_beat_t out_d;
  logic      adv_out;
  logic      adv_in;

  assign adv_out    = !out_vld_q || !out_stall_i;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_stall_o = !adv_in;

  logic [7:0]  dec_s, dec_mi, dec_h, dec_d, dec_wd, dec_mo, dec_yb;
  logic        dec_ok;
  logic        enc_year_ok;
  logic        enc_ok;
  logic [15:0] enc_yoff;
  logic [6:0]  enc_yy;
  logic [6:0]  z_k;
  logic        z_jterm;
  logic [7:0]  z_sum;
  logic [2:0]  z_h;
  logic [2:0]  z_wd;

  always_comb begin
    dec_s  = from_bcd(in_q.second_in & SecMask);
    dec_mi = from_bcd(in_q.minute_in & MinMask);
    dec_h  = from_bcd(in_q.hour_in & HourMask);
    dec_d  = from_bcd(in_q.day_in & DayMask);
    dec_wd = from_bcd(in_q.weekday_in & WdayMask);
    dec_mo = from_bcd(in_q.month_in & MonMask);
    dec_yb = from_bcd(in_q.year_in[7:0]);
    dec_ok = date_ok(dec_s, dec_mi, dec_h, dec_d, dec_wd, dec_mo,
                     dec_yb <= 8'd99, dec_yb[1:0] == 2'd0);

    enc_year_ok = (in_q.year_in >= YearBase) && (in_q.year_in <= YearLast);
    enc_ok      = date_ok(in_q.second_in, in_q.minute_in, in_q.hour_in,
                          in_q.day_in, in_q.weekday_in, in_q.month_in,
                          enc_year_ok, in_q.year_in[1:0] == 2'd0);
    enc_yoff    = in_q.year_in - YearBase;
    enc_yy      = enc_yoff[6:0];

    // January and February of 2000 fall back into 1999, with century term nineteen.
    z_jterm = 1'b0;
    z_k     = enc_yy;
    if (in_q.month_in < 8'd3) begin
      if (enc_yy == 7'd0) begin
        z_k     = 7'd99;
        z_jterm = 1'b1;
      end else begin
        z_k = enc_yy - 7'd1;
      end
    end
    z_sum = in_q.day_in + zeller_month(in_q.month_in) + {1'b0, z_k} +
            {3'd0, z_k[6:2]} + {7'd0, z_jterm};
    z_h   = mod7(z_sum);
    z_wd  = (z_h == 3'd0) ? 3'd6 : z_h - 3'd1;

    out_d = '0;
    unique case (in_q.cmd)
      CmdDecode: begin
        out_d.status      = !dec_ok;
        out_d.integrity   = !in_q.second_in[OscStopBit];
        out_d.second_out  = dec_s;
        out_d.minute_out  = dec_mi;
        out_d.hour_out    = dec_h;
        out_d.day_out     = dec_d;
        out_d.weekday_out = dec_wd;
        out_d.month_out   = dec_mo;
        out_d.year_out    = YearBase[11:0] + {4'd0, dec_yb};
      end
      CmdEncode: begin
        out_d.status = !enc_ok;
        if (enc_ok) begin
          out_d.second_out  = to_bcd(in_q.second_in[6:0]);
          out_d.minute_out  = to_bcd(in_q.minute_in[6:0]);
          out_d.hour_out    = to_bcd(in_q.hour_in[6:0]);
          out_d.day_out     = to_bcd(in_q.day_in[6:0]);
          out_d.weekday_out = to_bcd({4'd0, z_wd});
          out_d.month_out   = to_bcd(in_q.month_in[6:0]);
          out_d.year_out    = {4'd0, to_bcd(enc_yy)};
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= in_valid_i;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv_out && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
